@@ hdl/bscu_pkg.sv @@
// ----------------------------------------------------------------------------
// bscu_pkg
// Shared types, codes and helpers of the broadcast schedule checker.
// ----------------------------------------------------------------------------
package bscu_pkg;

  localparam int MAX_NODES_DEFAULT = 64;
  localparam int NODE_W            = 6;
  localparam int MASK_W            = 64;
  localparam int CFG_W             = 7;

  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_ADD_EDGE  = 3'd1;
  localparam logic [2:0] OP_MESSAGE   = 3'd2;
  localparam logic [2:0] OP_END_ROUND = 3'd3;
  localparam logic [2:0] OP_FINISH    = 3'd4;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_RANGE         = 3'd1;
  localparam logic [2:0] ST_SENDER_UNINF  = 3'd2;
  localparam logic [2:0] ST_RECEIVER_INF  = 3'd3;
  localparam logic [2:0] ST_NO_EDGE       = 3'd4;
  localparam logic [2:0] ST_SENDER_BUSY   = 3'd5;
  localparam logic [2:0] ST_EMPTY_ROUND   = 3'd6;
  localparam logic [2:0] ST_INCOMPLETE    = 3'd7;

  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_SOURCE_NODE = 1'b1;

  localparam logic [CFG_W-1:0]  NODE_COUNT_RESET  = 7'd64;
  localparam logic [NODE_W-1:0] SOURCE_NODE_RESET = 6'd0;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status_code;
    logic       schedule_valid;
    logic       is_final;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic step_a;
    logic step_b;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic op_edge;
  } dp_status_t;

  function automatic logic [MASK_W-1:0] bit_of(input logic [NODE_W-1:0] node);
    logic [MASK_W-1:0] m;
    m = '0;
    m[node] = 1'b1;
    return m;
  endfunction

endpackage

@@ hdl/bscu_ram.sv @@
// ----------------------------------------------------------------------------
// bscu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bscu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/bscu_ctrl.sv @@
// ----------------------------------------------------------------------------
// bscu_ctrl
// Sequencer: accept a transaction, run it through the datapath, post result.
// ----------------------------------------------------------------------------
module bscu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bscu_pkg::ctl_cmd_t  cmd,
  input  bscu_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_EDGE_B = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.op_edge) begin
          cmd.step_a = 1'b1;
          state_next = S_EDGE_B;
        end else if (out_free) begin
          cmd.step_a   = 1'b1;
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EDGE_B: begin
        if (out_free) begin
          cmd.step_b   = 1'b1;
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/bscu_dp.sv @@
// ----------------------------------------------------------------------------
// bscu_dp
// Datapath: configuration, adjacency store, round masks, checks and result.
// ----------------------------------------------------------------------------
module bscu_dp #(
  parameter int MAX_NODES = bscu_pkg::MAX_NODES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bscu_pkg::CFG_W-1:0]   cfg_data,
  input  bscu_pkg::in_item_t           in_data,
  input  bscu_pkg::ctl_cmd_t           cmd,
  output bscu_pkg::dp_status_t         status,
  output bscu_pkg::out_item_t          out_data
);

  localparam int DEPTH = (MAX_NODES < bscu_pkg::MASK_W) ? MAX_NODES : bscu_pkg::MASK_W;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [bscu_pkg::CFG_W-1:0] DEPTH7 = bscu_pkg::CFG_W'(DEPTH);

  logic [bscu_pkg::CFG_W-1:0]  node_count;
  logic [bscu_pkg::NODE_W-1:0] source_node;
  bscu_pkg::in_item_t          item;
  logic [DEPTH-1:0]            row_valid;
  logic [AW-1:0]               rd_idx;
  logic [bscu_pkg::MASK_W-1:0] informed;
  logic [bscu_pkg::MASK_W-1:0] newly;
  logic [bscu_pkg::MASK_W-1:0] sent;
  logic                        round_msg;
  logic [2:0]                  first_error;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [bscu_pkg::MASK_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [bscu_pkg::MASK_W-1:0] ram_rdata;

  logic [bscu_pkg::MASK_W-1:0] row;
  logic [bscu_pkg::CFG_W-1:0]  n7;
  logic [bscu_pkg::MASK_W-1:0] need;
  logic                        edge_ok;
  logic                        same;
  logic                        is_edge;
  logic [2:0]                  msg_err;
  logic [2:0]                  err_next;

  bscu_ram #(
    .WIDTH (bscu_pkg::MASK_W),
    .DEPTH (DEPTH)
  ) u_adj_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign is_edge        = (item.opcode == bscu_pkg::OP_ADD_EDGE);
  assign status.op_edge = is_edge;
  assign row     = row_valid[rd_idx] ? ram_rdata : '0;
  assign n7      = (node_count > DEPTH7) ? DEPTH7 : node_count;
  assign edge_ok = ({1'b0, item.node_a} < DEPTH7) && ({1'b0, item.node_b} < DEPTH7);
  assign same    = (item.node_a == item.node_b);

  always_comb begin
    for (int i = 0; i < bscu_pkg::MASK_W; i++) begin
      need[i] = (bscu_pkg::CFG_W'(i) < n7);
    end
  end

  always_comb begin
    priority if (({1'b0, item.node_a} >= n7) || ({1'b0, item.node_b} >= n7)) begin
      msg_err = bscu_pkg::ST_RANGE;
    end else if (!informed[item.node_a]) begin
      msg_err = bscu_pkg::ST_SENDER_UNINF;
    end else if (informed[item.node_b]) begin
      msg_err = bscu_pkg::ST_RECEIVER_INF;
    end else if (!row[item.node_b]) begin
      msg_err = bscu_pkg::ST_NO_EDGE;
    end else if (sent[item.node_a]) begin
      msg_err = bscu_pkg::ST_SENDER_BUSY;
    end else begin
      msg_err = bscu_pkg::ST_OK;
    end
  end

  always_comb begin
    err_next = first_error;
    case (item.opcode)
      bscu_pkg::OP_CLEAR: begin
        err_next = bscu_pkg::ST_OK;
      end
      bscu_pkg::OP_MESSAGE: begin
        if (first_error == bscu_pkg::ST_OK) begin
          err_next = msg_err;
        end
      end
      bscu_pkg::OP_END_ROUND: begin
        if (first_error == bscu_pkg::ST_OK && !round_msg) begin
          err_next = bscu_pkg::ST_EMPTY_ROUND;
        end
      end
      bscu_pkg::OP_FINISH: begin
        if (first_error == bscu_pkg::ST_OK && (informed & need) != need) begin
          err_next = bscu_pkg::ST_INCOMPLETE;
        end
      end
      default: begin
        err_next = first_error;
      end
    endcase
  end

  assign ram_re    = cmd.accept || (cmd.step_a && is_edge);
  assign ram_raddr = cmd.accept ? in_data.node_a[AW-1:0] : item.node_b[AW-1:0];
  assign ram_we    = edge_ok && ((cmd.step_a && is_edge && !same) || cmd.step_b);
  assign ram_waddr = cmd.step_b ? item.node_b[AW-1:0] : item.node_a[AW-1:0];
  assign ram_wdata = row | bscu_pkg::bit_of(cmd.step_b ? item.node_a : item.node_b);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
    end
    if (ram_re) begin
      rd_idx <= ram_raddr;
    end
    if (cmd.load_out) begin
      out_data.status_code    <= err_next;
      out_data.schedule_valid <= (item.opcode == bscu_pkg::OP_FINISH) &&
                                 (err_next == bscu_pkg::ST_OK);
      out_data.is_final       <= (item.opcode == bscu_pkg::OP_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= bscu_pkg::NODE_COUNT_RESET;
      source_node <= bscu_pkg::SOURCE_NODE_RESET;
      row_valid   <= '0;
      informed    <= '0;
      newly       <= '0;
      sent        <= '0;
      round_msg   <= 1'b0;
      first_error <= bscu_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bscu_pkg::REG_NODE_COUNT:  node_count  <= cfg_data;
          bscu_pkg::REG_SOURCE_NODE: source_node <= cfg_data[bscu_pkg::NODE_W-1:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (cmd.step_a) begin
        first_error <= err_next;
        case (item.opcode)
          bscu_pkg::OP_CLEAR: begin
            row_valid <= '0;
            informed  <= bscu_pkg::bit_of(source_node);
            newly     <= '0;
            sent      <= '0;
            round_msg <= 1'b0;
          end
          bscu_pkg::OP_MESSAGE: begin
            if (first_error == bscu_pkg::ST_OK && msg_err == bscu_pkg::ST_OK) begin
              sent      <= sent | bscu_pkg::bit_of(item.node_a);
              newly     <= newly | bscu_pkg::bit_of(item.node_b);
              round_msg <= 1'b1;
            end
          end
          bscu_pkg::OP_END_ROUND: begin
            if (first_error == bscu_pkg::ST_OK && round_msg) begin
              informed  <= informed | newly;
              newly     <= '0;
              sent      <= '0;
              round_msg <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ hdl/broadcast_schedule_checker_unit.sv @@
// ----------------------------------------------------------------------------
// broadcast_schedule_checker_unit
// Checks a round-based broadcast schedule on an undirected graph.
// ----------------------------------------------------------------------------
//  channel  | signals                         | payload
//  ---------+---------------------------------+------------------------------
//  input    | in_valid / in_ready / in_data    | opcode, node_a, node_b
//  output   | out_valid / out_ready / out_data | status_code, schedule_valid,
//           |                                  | is_final
//  config   | cfg_we / cfg_index / cfg_data    | node_count, source_node
//
//  Clear, message, end round, finish and unused opcodes: the adjacency row
//  of node_a is read from the registered-read RAM, then checked.
//  Add edge: row a and row b are each read, modified, written.
//  Reset is synchronous; adjacency rows read as zero until written, tracked
//  by one valid flag per row, so no clearing pass is needed.
//  A result not yet taken holds the transaction in execute, or in edge b for
//  add edge; no new input transaction is accepted meanwhile.
// ----------------------------------------------------------------------------
module broadcast_schedule_checker_unit #(
  parameter int MAX_NODES = bscu_pkg::MAX_NODES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bscu_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bscu_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bscu_pkg::CFG_W-1:0] cfg_data
);

  bscu_pkg::ctl_cmd_t   ctl_cmd;
  bscu_pkg::dp_status_t dp_status;

  bscu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (ctl_cmd),
    .status    (dp_status)
  );

  bscu_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (ctl_cmd),
    .status    (dp_status),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  a_valid_only_final_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.schedule_valid |->
      out_data.is_final && out_data.status_code == bscu_pkg::ST_OK)
    else $error("schedule_valid without an ok finish");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.load_out |-> !out_valid || out_ready)
    else $error("result overwritten before it was taken");

endmodule
